// ===== rtl/dph_pkg.sv =====
// dph_pkg: shared types and constants for the deadband PID heading block.
// No dependencies.
package dph_pkg;
    localparam int WINDOW_DEF = 16;

    localparam logic [31:0] GAIN_P_RST  = 32'd335544;
    localparam logic [30:0] TSTEP_RST   = 31'd65536;

    typedef enum logic [2:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_TSTEP    = 3'd3,
        REG_DEADBAND = 3'd4
    } reg_idx_t;

    // one-hot sequencer states
    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_FRD    = 15'b000000000000010,
        ST_FSUM   = 15'b000000000000100,
        ST_FDIV   = 15'b000000000001000,
        ST_CHK    = 15'b000000000010000,
        ST_INTM   = 15'b000000000100000,
        ST_INTA   = 15'b000000001000000,
        ST_DDIV   = 15'b000000010000000,
        ST_PM     = 15'b000000100000000,
        ST_IM     = 15'b000001000000000,
        ST_DM     = 15'b000010000000000,
        ST_HSUM   = 15'b000100000000000,
        ST_HRD    = 15'b001000000000000,
        ST_HDIV   = 15'b010000000000000,
        ST_OUT    = 15'b100000000000000
    } state_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)       return 32'h7fffffff;
        else if (x < -64'sd2147483648) return 32'h80000000;
        else                           return x[31:0];
    endfunction

    function automatic logic is_clip(input logic signed [63:0] x);
        return (x > 64'sd2147483647) || (x < -64'sd2147483648);
    endfunction
endpackage

// ===== rtl/deadband_pid_heading_with_moving_average.sv =====
// Deadband PID heading controller with two moving-average windows.
// Depends on dph_pkg and dph_div.
//
// Channel  | dir | handshake      | payload
// -------- | --- | -------------- | -------------------------------------
// in       | in  | in_valid/stall | lateral_force, base_heading
// out      | out | out_valid/stall| opt_heading, pid_active, saturated
// cfg      | in  | cfg_valid/rdy  | cfg_index, cfg_data
//
// One item at a time. An inactive item shows its result once it has passed
// one 64-step division of the force sum by the fill count; an active one
// also runs the shared divider for the derivative (skipped with a zero time
// step) and the heading average, plus four multiplies.
// Windows live in two RAMs with registered reads.
// Reset clears sums, fills, integral, previous error and held heading.
// The result sits in an output register; a stalled output holds it and
// the next item is taken once the previous result has been delivered.
module deadband_pid_heading_with_moving_average
    import dph_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] lateral_force,
    input  logic [31:0] base_heading,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] opt_heading,
    output logic        pid_active,
    output logic        saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW = $clog2(WINDOW + 1);

    // configuration
    logic [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [30:0] tstep_reg, deadband_reg;

    // window RAMs; entries undefined until written
    logic [31:0] fmem [WINDOW];
    logic [31:0] hmem [WINDOW];
    logic [31:0] frd_reg, hrd_reg;

    logic [FW-1:0] ffill_reg, hfill_reg;
    logic [AW-1:0] fpos_reg, hpos_reg;
    logic signed [39:0] fsum_reg, hsum_reg;
    logic signed [31:0] integ_reg, perr_reg, held_reg;

    state_t state_reg;
    logic [31:0] force_reg, base_reg;
    logic signed [31:0] err_reg, deriv_reg;
    logic signed [63:0] prod_reg;
    logic signed [40:0] pid_reg;
    logic        clip_reg;
    logic signed [31:0] head_reg;

    // divider
    logic               div_start;
    logic signed [63:0] div_num;
    logic        [31:0] div_den;
    logic               div_done;
    logic signed [63:0] div_q;
    logic               div_wait_reg;

    dph_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_stall  = (state_reg != ST_IDLE) || out_valid;
    assign cfg_ready = 1'b1;

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    logic [FW-1:0] ffill_new, hfill_new;
    assign ffill_new = (ffill_reg == FW'(WINDOW)) ? ffill_reg : ffill_reg + 1'b1;
    assign hfill_new = (hfill_reg == FW'(WINDOW)) ? hfill_reg : hfill_reg + 1'b1;

    logic signed [39:0] fsum_new, hsum_new;
    assign fsum_new = fsum_reg + 40'(signed'(force_reg))
                    - ((ffill_reg == FW'(WINDOW)) ? 40'(signed'(frd_reg)) : 40'sd0);
    assign hsum_new = hsum_reg + 40'(signed'(head_reg))
                    - ((hfill_reg == FW'(WINDOW)) ? 40'(signed'(hrd_reg)) : 40'sd0);

    logic signed [32:0] mag;
    assign mag = err_reg[31] ? -33'(err_reg) : 33'(err_reg);

    logic signed [63:0] int_prod, mul_a, mul_b, int_sum, pid_term, head_sum;
    logic signed [32:0] derr;
    assign derr     = 33'(err_reg) - 33'(perr_reg);
    assign pid_term = prod_reg >>> 24;
    assign int_sum  = 64'(integ_reg) + (prod_reg >>> 16);
    assign head_sum = 64'(signed'(base_reg)) + 64'(pid_reg);

    // shared 32x32 multiplier operand select
    always_comb
    begin
        mul_a = 64'(signed'(err_reg));
        mul_b = 64'($signed({1'b0, tstep_reg}));
        case (state_reg)
            ST_PM:   mul_b = 64'(signed'(gain_p_reg));
            ST_IM:
            begin
                mul_a = 64'(integ_reg);
                mul_b = 64'(signed'(gain_i_reg));
            end
            ST_DM:
            begin
                mul_a = 64'(deriv_reg);
                mul_b = 64'(signed'(gain_d_reg));
            end
            default: ;
        endcase
        int_prod = mul_a * mul_b;
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = 64'(fsum_new);
        div_den   = 32'(ffill_new);
        case (state_reg)
            ST_FSUM: div_start = 1'b1;
            ST_INTA:
            begin
                div_start = (tstep_reg != 31'd0);
                div_num   = 64'(derr) <<< 16;
                div_den   = {1'b0, tstep_reg};
            end
            ST_HRD:
            begin
                div_start = 1'b1;
                div_num   = 64'(hsum_new);
                div_den   = 32'(hfill_new);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        frd_reg <= fmem[fpos_reg];
        hrd_reg <= hmem[hpos_reg];
        if (state_reg == ST_FSUM)
            fmem[fpos_reg] <= force_reg;
        if (state_reg == ST_HRD)
            hmem[hpos_reg] <= head_reg;
        prod_reg <= int_prod;
        if (in_acc)
        begin
            force_reg <= lateral_force;
            base_reg  <= base_heading;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= GAIN_P_RST;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            tstep_reg    <= TSTEP_RST;
            deadband_reg <= '0;
            state_reg    <= ST_IDLE;
            ffill_reg    <= '0;
            hfill_reg    <= '0;
            fpos_reg     <= '0;
            hpos_reg     <= '0;
            fsum_reg     <= '0;
            hsum_reg     <= '0;
            integ_reg    <= '0;
            perr_reg     <= '0;
            held_reg     <= '0;
            err_reg      <= '0;
            deriv_reg    <= '0;
            pid_reg      <= '0;
            head_reg     <= '0;
            clip_reg     <= 1'b0;
            div_wait_reg <= 1'b0;
            out_valid    <= 1'b0;
            opt_heading  <= '0;
            pid_active   <= 1'b0;
            saturated    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_P:   gain_p_reg   <= cfg_data;
                    REG_GAIN_I:   gain_i_reg   <= cfg_data;
                    REG_GAIN_D:   gain_d_reg   <= cfg_data;
                    REG_TSTEP:    tstep_reg    <= cfg_data[30:0];
                    REG_DEADBAND: deadband_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                out_valid <= 1'b0;

            case (state_reg)
                ST_IDLE:
                    if (in_acc)
                        state_reg <= ST_FRD;
                ST_FRD:   state_reg <= ST_FSUM;   // RAM read of oldest entry
                ST_FSUM:
                begin
                    fsum_reg  <= fsum_new;
                    ffill_reg <= ffill_new;
                    fpos_reg  <= (fpos_reg == AW'(WINDOW - 1)) ? '0 : fpos_reg + 1'b1;
                    clip_reg  <= 1'b0;
                    state_reg <= ST_FDIV;
                end
                ST_FDIV:
                    if (div_done)
                    begin
                        err_reg   <= div_q[31:0];
                        state_reg <= ST_CHK;
                    end
                ST_CHK:
                    if (mag > 33'($signed({2'b0, deadband_reg})))
                        state_reg <= ST_INTM;
                    else
                    begin
                        out_valid   <= 1'b1;
                        opt_heading <= held_reg;
                        pid_active  <= 1'b0;
                        saturated   <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                ST_INTM:  state_reg <= ST_INTA;   // err*dt in prod_reg next
                ST_INTA:
                begin
                    integ_reg <= sat32(int_sum);
                    if (is_clip(int_sum))
                        clip_reg <= 1'b1;
                    deriv_reg    <= '0;
                    div_wait_reg <= (tstep_reg != 31'd0);
                    state_reg    <= ST_DDIV;
                end
                ST_DDIV:
                    if (!div_wait_reg || div_done)
                    begin
                        if (div_wait_reg)
                        begin
                            deriv_reg <= sat32(div_q);
                            if (is_clip(div_q))
                                clip_reg <= 1'b1;
                        end
                        perr_reg  <= err_reg;
                        pid_reg   <= '0;
                        state_reg <= ST_PM;
                    end
                ST_PM:    state_reg <= ST_IM;
                ST_IM:
                begin
                    pid_reg   <= pid_reg + 41'(pid_term);
                    state_reg <= ST_DM;
                end
                ST_DM:
                begin
                    pid_reg   <= pid_reg + 41'(pid_term);
                    state_reg <= ST_HSUM;
                end
                ST_HSUM:
                begin
                    // D product lands now; pid_reg holds P + I
                    head_reg <= sat32(head_sum + 64'(pid_term));
                    if (is_clip(head_sum + 64'(pid_term)))
                        clip_reg <= 1'b1;
                    state_reg <= ST_HRD;
                end
                ST_HRD:   state_reg <= ST_HDIV;
                ST_HDIV:
                    if (div_done)
                    begin
                        held_reg    <= div_q[31:0];
                        out_valid   <= 1'b1;
                        opt_heading <= div_q[31:0];
                        pid_active  <= 1'b1;
                        saturated   <= clip_reg;
                        state_reg   <= ST_IDLE;
                    end
                default:  state_reg <= ST_IDLE;
            endcase

            if (state_reg == ST_HRD)
            begin
                hsum_reg  <= hsum_new;
                hfill_reg <= hfill_new;
                hpos_reg  <= (hpos_reg == AW'(WINDOW - 1)) ? '0 : hpos_reg + 1'b1;
            end
        end
    end

    // ---------------- assertions ----------------
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ffill_reg <= FW'(WINDOW)) && (hfill_reg <= FW'(WINDOW)))
        else $error("fill count overran window");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(opt_heading)))
        else $error("stalled result changed");
    a_idle_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pid_active) |-> !saturated)
        else $error("saturated set on inactive item");
endmodule

// ===== rtl/dph_div.sv =====
// dph_div: signed restoring divider, one quotient bit per cycle,
// quotient truncated toward zero. Uses dph_pkg.
module dph_div
    import dph_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic        [31:0] divisor,   // positive, nonzero
    output logic               done,
    output logic signed [63:0] quotient
);
    logic [63:0] num_reg, num_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] dvs_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] trial;
    logic [63:0] shifted;

    always_comb
    begin
        shifted   = {rem_reg[62:0], num_reg[63]};
        trial     = {1'b0, shifted} - {33'd0, dvs_reg};
        num_next  = {num_reg[62:0], 1'b0};
        rem_next  = shifted;
        if (!trial[64])
        begin
            rem_next    = trial[63:0];
            num_next[0] = 1'b1;
        end
        cnt_next  = cnt_reg - 7'd1;
        busy_next = busy_reg && (cnt_reg != 7'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= busy_reg && (cnt_reg == 7'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend[63] ? 64'(-dividend) : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[63];
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);
endmodule
